FILE: sv/light_bar_quad_vertex_select_macros.svh
// Assertion macros shared by the checker file.
`ifndef LIGHT_BAR_QUAD_VERTEX_SELECT_MACROS_SVH
`define LIGHT_BAR_QUAD_VERTEX_SELECT_MACROS_SVH

// Same-cycle implication, masked while in reset.
`define LBQVS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lbqvs assertion failed");

// Next-cycle implication, masked while in reset.
`define LBQVS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lbqvs assertion failed");

`endif

FILE: sv/lbqvs_pkg.sv
package lbqvs_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int NUM_CORNERS    = 4;
  localparam int NUM_PAIRS      = 6;
  localparam int NUM_DIST       = 20;

  typedef struct packed {
    logic [1:0] t0;
    logic [1:0] t1;
    logic [1:0] b0;
    logic [1:0] b1;
    logic       fb;
  } grp_t;

  function automatic logic [2:0] pair_idx(input logic [1:0] i, input logic [1:0] j);
    logic [1:0] lo;
    logic [1:0] hi;
    logic [2:0] r;
    lo = (i < j) ? i : j;
    hi = (i < j) ? j : i;
    r  = 3'd5;
    if (lo == 2'd0) r = 3'(hi) - 3'd1;
    else if (lo == 2'd1) r = 3'(hi) + 3'd1;
    return r;
  endfunction

  function automatic int pair_a(input int p);
    int r;
    case (p)
      0, 1, 2: r = 0;
      3, 4:    r = 1;
      default: r = 2;
    endcase
    return r;
  endfunction

  function automatic int pair_b(input int p);
    int r;
    case (p)
      0:       r = 1;
      1, 3:    r = 2;
      default: r = 3;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/lbqvs_dist.sv
module lbqvs_dist #(
  parameter int COORD_BITS = 16
) (
  input  logic                        clk,
  input  logic [2:0]                  en,
  input  logic [2*COORD_BITS-1:0]     pt_a,
  input  logic [2*COORD_BITS-1:0]     pt_b,
  output logic [2*COORD_BITS+2:0]     sq_d
);
  localparam int C  = COORD_BITS;
  localparam int DW = 2 * C + 3;

  logic [C:0]      dx_r, dy_r;
  logic [2*C+1:0]  sx_r, sy_r;
  logic [DW-1:0]   sum_r;
  logic [C:0]      ddx, ddy;

  assign ddx = {pt_a[2*C-1], pt_a[2*C-1:C]} - {pt_b[2*C-1], pt_b[2*C-1:C]};
  assign ddy = {pt_a[C-1], pt_a[C-1:0]} - {pt_b[C-1], pt_b[C-1:0]};

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dx_r <= ddx[C] ? (~ddx + 1'b1) : ddx;
      dy_r <= ddy[C] ? (~ddy + 1'b1) : ddy;
    end
    if (en[1]) begin
      sx_r <= (2*C+2)'(dx_r) * (2*C+2)'(dx_r);
      sy_r <= (2*C+2)'(dy_r) * (2*C+2)'(dy_r);
    end
    if (en[2]) begin
      sum_r <= DW'(sx_r) + DW'(sy_r);
    end
  end

  assign sq_d = sum_r;
endmodule

FILE: sv/lbqvs_split.sv
module lbqvs_split #(
  parameter int COORD_BITS = 16
) (
  input  logic [7:0]                  near,
  input  logic [4*COORD_BITS-1:0]     ys,
  output lbqvs_pkg::grp_t             grp
);
  import lbqvs_pkg::*;
  localparam int C = COORD_BITS;

  logic signed [C-1:0] y [4];
  logic [1:0]          nr [4];
  logic [3:0]          used;
  logic [2:0]          cnt;
  logic [1:0]          pa [2];
  logic [1:0]          pb [2];
  logic [1:0]          rank [4];
  logic [1:0]          srt [4];
  logic signed [C:0]   s1, s2;
  logic                t;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      y[i]  = signed'(ys[i*C +: C]);
      nr[i] = near[i*2 +: 2];
    end
    used = '0;
    cnt  = '0;
    pa[0] = '0; pa[1] = '0; pb[0] = '0; pb[1] = '0;
    for (int i = 0; i < 4; i++) begin
      if (!used[i] && !used[nr[i]]) begin
        if (cnt == 3'd0) begin pa[0] = 2'(i); pb[0] = nr[i]; end
        if (cnt == 3'd1) begin pa[1] = 2'(i); pb[1] = nr[i]; end
        if (cnt != 3'd7) cnt = cnt + 3'd1;
        used[i]     = 1'b1;
        used[nr[i]] = 1'b1;
      end
    end
    for (int i = 0; i < 4; i++) begin
      rank[i] = '0;
      for (int j = 0; j < 4; j++) begin
        if (j < i && y[j] <= y[i]) rank[i] = rank[i] + 2'd1;
        if (j > i && y[j] < y[i])  rank[i] = rank[i] + 2'd1;
      end
    end
    for (int p = 0; p < 4; p++) begin
      srt[p] = '0;
      for (int i = 0; i < 4; i++) begin
        if (rank[i] == 2'(p)) srt[p] = 2'(i);
      end
    end
    s1 = (C+1)'(y[pa[0]]) + (C+1)'(y[pb[0]]);
    s2 = (C+1)'(y[pa[1]]) + (C+1)'(y[pb[1]]);
    t  = !(s1 < s2);
    if (cnt != 3'd2) begin
      grp.t0 = srt[0]; grp.t1 = srt[1]; grp.b0 = srt[2]; grp.b1 = srt[3];
      grp.fb = 1'b1;
    end else begin
      grp.t0 = t ? pa[1] : pa[0];
      grp.t1 = t ? pb[1] : pb[0];
      grp.b0 = t ? pa[0] : pa[1];
      grp.b1 = t ? pb[0] : pb[1];
      grp.fb = 1'b0;
    end
  end
endmodule

FILE: sv/light_bar_quad_vertex_select.sv
// Structure: a 7-stage pipeline from input transfer to result
//   (difference, square, sum, nearest corner, grouping, pick, x sort).
// Throughput: one item per cycle while not stalled; a stall holds each full stage that cannot pass on its item.
// Reset: synchronous, active low, clears all stage valid bits.
module light_bar_quad_vertex_select #(
  parameter int COORD_BITS = lbqvs_pkg::COORD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [2*COORD_BITS-1:0] in_left_corner_0,
  input  logic [2*COORD_BITS-1:0] in_left_corner_1,
  input  logic [2*COORD_BITS-1:0] in_left_corner_2,
  input  logic [2*COORD_BITS-1:0] in_left_corner_3,
  input  logic [2*COORD_BITS-1:0] in_right_corner_0,
  input  logic [2*COORD_BITS-1:0] in_right_corner_1,
  input  logic [2*COORD_BITS-1:0] in_right_corner_2,
  input  logic [2*COORD_BITS-1:0] in_right_corner_3,
  input  logic [2*COORD_BITS-1:0] in_left_center,
  input  logic [2*COORD_BITS-1:0] in_right_center,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [2*COORD_BITS-1:0] out_top_left,
  output logic [2*COORD_BITS-1:0] out_top_right,
  output logic [2*COORD_BITS-1:0] out_bottom_right,
  output logic [2*COORD_BITS-1:0] out_bottom_left,
  output logic                    out_left_fallback,
  output logic                    out_right_fallback
);
  import lbqvs_pkg::*;
  localparam int C  = COORD_BITS;
  localparam int PW = 2 * C;
  localparam int DW = 2 * C + 3;

  logic [6:0]    v_r, v_nxt;
  logic [6:0]    rdy;
  logic [PW-1:0] in_pt [8];
  logic [PW-1:0] pt_r [5][8];
  logic [DW-1:0] d [NUM_DIST];
  logic [DW-1:0] cd3_r [8];
  logic [DW-1:0] cd4_r [8];
  logic [1:0]    near_nxt [8];
  logic [1:0]    near_r [8];
  grp_t          grp_c [2];
  grp_t          grp_r [2];
  logic [PW-1:0] a_nxt [4];
  logic [PW-1:0] a_r [4];
  logic [1:0]    fb5_r;
  logic [1:0]    xr [4];
  logic [PW-1:0] s [4];
  logic [PW-1:0] tl_nxt, tr_nxt, br_nxt, bl_nxt;
  logic [PW-1:0] tl_r, tr_r, br_r, bl_r;
  logic [1:0]    fb_r;

  assign in_pt[0] = in_left_corner_0;
  assign in_pt[1] = in_left_corner_1;
  assign in_pt[2] = in_left_corner_2;
  assign in_pt[3] = in_left_corner_3;
  assign in_pt[4] = in_right_corner_0;
  assign in_pt[5] = in_right_corner_1;
  assign in_pt[6] = in_right_corner_2;
  assign in_pt[7] = in_right_corner_3;

  always_comb begin
    rdy[6] = !v_r[6] || !out_stall;
    for (int k = 5; k >= 0; k--) rdy[k] = !v_r[k] || rdy[k+1];
    v_nxt[0] = rdy[0] ? in_valid : v_r[0];
    for (int k = 1; k < 7; k++) v_nxt[k] = rdy[k] ? v_r[k-1] : v_r[k];
  end

  assign in_stall = !rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  for (genvar b = 0; b < 2; b++) begin : g_bar
    for (genvar p = 0; p < NUM_PAIRS; p++) begin : g_pair
      lbqvs_dist #(.COORD_BITS(C)) u_dist (
        .clk  (clk),
        .en   (rdy[2:0]),
        .pt_a (in_pt[b*4 + pair_a(p)]),
        .pt_b (in_pt[b*4 + pair_b(p)]),
        .sq_d (d[b*NUM_PAIRS + p])
      );
    end
  end

  for (genvar k = 0; k < 8; k++) begin : g_ctr
    lbqvs_dist #(.COORD_BITS(C)) u_dist (
      .clk  (clk),
      .en   (rdy[2:0]),
      .pt_a (in_pt[k]),
      .pt_b ((k < 4) ? in_right_center : in_left_center),
      .sq_d (d[12 + k])
    );
  end

  always_comb begin
    logic [1:0] best;
    logic       found;
    for (int b = 0; b < 2; b++) begin
      for (int i = 0; i < 4; i++) begin
        best  = '0;
        found = 1'b0;
        for (int j = 0; j < 4; j++) begin
          if (j != i) begin
            if (!found) begin
              best  = 2'(j);
              found = 1'b1;
            end else if (d[5'(b*NUM_PAIRS) + 5'(pair_idx(2'(i), 2'(j)))]
                         < d[5'(b*NUM_PAIRS) + 5'(pair_idx(2'(i), best))]) begin
              best = 2'(j);
            end
          end
        end
        near_nxt[{1'(b), 2'(i)}] = best;
      end
    end
  end

  for (genvar b = 0; b < 2; b++) begin : g_split
    lbqvs_split #(.COORD_BITS(C)) u_split (
      .near ({near_r[b*4+3], near_r[b*4+2], near_r[b*4+1], near_r[b*4]}),
      .ys   ({pt_r[3][b*4+3][C-1:0], pt_r[3][b*4+2][C-1:0],
              pt_r[3][b*4+1][C-1:0], pt_r[3][b*4][C-1:0]}),
      .grp  (grp_c[b])
    );
  end

  always_comb begin
    for (int b = 0; b < 2; b++) begin
      a_nxt[b*2]   = (cd4_r[{1'(b), grp_r[b].t1}] < cd4_r[{1'(b), grp_r[b].t0}])
                     ? pt_r[4][{1'(b), grp_r[b].t1}] : pt_r[4][{1'(b), grp_r[b].t0}];
      a_nxt[b*2+1] = (cd4_r[{1'(b), grp_r[b].b1}] < cd4_r[{1'(b), grp_r[b].b0}])
                     ? pt_r[4][{1'(b), grp_r[b].b1}] : pt_r[4][{1'(b), grp_r[b].b0}];
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      xr[i] = '0;
      for (int j = 0; j < 4; j++) begin
        if (j < i && signed'(a_r[j][PW-1:C]) <= signed'(a_r[i][PW-1:C])) xr[i] = xr[i] + 2'd1;
        if (j > i && signed'(a_r[j][PW-1:C]) < signed'(a_r[i][PW-1:C]))  xr[i] = xr[i] + 2'd1;
      end
    end
    for (int p = 0; p < 4; p++) begin
      s[p] = a_r[0];
      for (int i = 0; i < 4; i++) begin
        if (xr[i] == 2'(p)) s[p] = a_r[i];
      end
    end
    if (signed'(s[0][C-1:0]) < signed'(s[1][C-1:0])) begin
      tl_nxt = s[0]; bl_nxt = s[1];
    end else begin
      tl_nxt = s[1]; bl_nxt = s[0];
    end
    if (signed'(s[2][C-1:0]) < signed'(s[3][C-1:0])) begin
      tr_nxt = s[2]; br_nxt = s[3];
    end else begin
      tr_nxt = s[3]; br_nxt = s[2];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 8; k++) begin
      if (rdy[0]) pt_r[0][k] <= in_pt[k];
      for (int st = 1; st < 5; st++) begin
        if (rdy[st]) pt_r[st][k] <= pt_r[st-1][k];
      end
      if (rdy[3]) begin
        cd3_r[k]  <= d[12 + k];
        near_r[k] <= near_nxt[k];
      end
      if (rdy[4]) cd4_r[k] <= cd3_r[k];
    end
    if (rdy[4]) begin
      grp_r[0] <= grp_c[0];
      grp_r[1] <= grp_c[1];
    end
    if (rdy[5]) begin
      for (int i = 0; i < 4; i++) a_r[i] <= a_nxt[i];
      fb5_r <= {grp_r[1].fb, grp_r[0].fb};
    end
    if (rdy[6]) begin
      tl_r <= tl_nxt;
      tr_r <= tr_nxt;
      br_r <= br_nxt;
      bl_r <= bl_nxt;
      fb_r <= fb5_r;
    end
  end

  assign out_valid          = v_r[6];
  assign out_top_left       = tl_r;
  assign out_top_right      = tr_r;
  assign out_bottom_right   = br_r;
  assign out_bottom_left    = bl_r;
  assign out_left_fallback  = fb_r[0];
  assign out_right_fallback = fb_r[1];
endmodule

FILE: sv/lbqvs_checker.sv
`include "light_bar_quad_vertex_select_macros.svh"

module lbqvs_checker #(
  parameter int COORD_BITS = lbqvs_pkg::COORD_BITS_DEF
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [2*COORD_BITS-1:0] out_top_left,
  input logic                    out_left_fallback
);
  `LBQVS_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid)
  `LBQVS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `LBQVS_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_top_left) && $stable(out_left_fallback))
  `LBQVS_ASSERT_NOW(a_stall_only_full, in_stall, out_valid && out_stall)
  `LBQVS_ASSERT_NOW(a_reset_empty, $past(!rst_n), !out_valid && !in_stall)
endmodule

bind light_bar_quad_vertex_select lbqvs_checker #(.COORD_BITS(COORD_BITS)) u_lbqvs_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_top_left      (out_top_left),
  .out_left_fallback (out_left_fallback)
);

FILE: sim/tb_light_bar_quad_vertex_select.sv
module tb_light_bar_quad_vertex_select;
  import lbqvs_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int PW = 2 * CB;
  localparam int WATCH_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;

  typedef logic [PW-1:0] pt_t;
  typedef pt_t bar_t [4];
  typedef struct {
    pt_t tl, tr, br, bl;
    bit lf, rf;
  } quad_t;
  typedef struct {
    pt_t v [10];
    bit typed;
    quad_t q;
  } row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  pt_t in_v [10];
  logic out_valid;
  logic out_stall = 0;
  pt_t out_top_left, out_top_right, out_bottom_right, out_bottom_left;
  logic out_left_fallback, out_right_fallback;

  quad_t quads_due [$];
  int errors = 0;
  int tx_idle = 0, rx_idle = 0;
  int hold_req = 0, hold_seen = 0, hold_cnt = 0;
  int quiet = 0;
  bit cur_typed = 0;
  quad_t cur_quad;
  row_t rows [$];

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial for (int i = 0; i < 10; i++) in_v[i] = '0;

  light_bar_quad_vertex_select dut (
    .clk, .rst_n, .in_valid, .in_stall,
    .in_left_corner_0(in_v[0]), .in_left_corner_1(in_v[1]),
    .in_left_corner_2(in_v[2]), .in_left_corner_3(in_v[3]),
    .in_right_corner_0(in_v[4]), .in_right_corner_1(in_v[5]),
    .in_right_corner_2(in_v[6]), .in_right_corner_3(in_v[7]),
    .in_left_center(in_v[8]), .in_right_center(in_v[9]),
    .out_valid, .out_stall, .out_top_left, .out_top_right,
    .out_bottom_right, .out_bottom_left, .out_left_fallback, .out_right_fallback
  );

  function automatic longint px(pt_t p);
    return longint'($signed(p[PW-1:CB]));
  endfunction

  function automatic longint py(pt_t p);
    return longint'($signed(p[CB-1:0]));
  endfunction

  function automatic longint dsq(pt_t a, pt_t b);
    longint dx, dy;
    dx = px(a) - px(b);
    dy = py(a) - py(b);
    return dx * dx + dy * dy;
  endfunction

  function automatic bit split_corners(bar_t p, output pt_t t0, t1, b0, b1);
    int nearest [4];
    int pa [2], pb [2];
    int cnt, best, n, sel;
    bit used [4];
    pt_t s [4];
    pt_t tmp;
    int j;
    longint s1, s2;
    cnt = 0;
    pa = '{0, 0};
    pb = '{0, 0};
    used = '{0, 0, 0, 0};
    for (int i = 0; i < 4; i++) begin
      best = -1;
      for (int k = 0; k < 4; k++) begin
        if (k != i && (best < 0 || dsq(p[i], p[k]) < dsq(p[i], p[best]))) best = k;
      end
      nearest[i] = best;
    end
    for (int i = 0; i < 4; i++) begin
      n = nearest[i];
      if (!used[i] && !used[n]) begin
        if (cnt < 2) begin
          pa[cnt] = i;
          pb[cnt] = n;
        end
        cnt++;
        used[i] = 1;
        used[n] = 1;
      end
    end
    if (cnt != 2) begin
      for (int i = 0; i < 4; i++) begin
        tmp = p[i];
        j = i;
        while (j > 0 && py(tmp) < py(s[j-1])) begin
          s[j] = s[j-1];
          j--;
        end
        s[j] = tmp;
      end
      t0 = s[0]; t1 = s[1]; b0 = s[2]; b1 = s[3];
      return 1;
    end
    s1 = py(p[pa[0]]) + py(p[pb[0]]);
    s2 = py(p[pa[1]]) + py(p[pb[1]]);
    sel = (s1 < s2) ? 0 : 1;
    t0 = p[pa[sel]]; t1 = p[pb[sel]];
    b0 = p[pa[1-sel]]; b1 = p[pb[1-sel]];
    return 0;
  endfunction

  function automatic pt_t nearer(pt_t g0, pt_t g1, pt_t c);
    return (dsq(g1, c) < dsq(g0, c)) ? g1 : g0;
  endfunction

  function automatic quad_t select_quad(pt_t v [10]);
    bar_t lb, rb;
    pt_t lt0, lt1, lb0, lb1, rt0, rt1, rb0, rb1, tmp;
    pt_t a [4], s [4];
    quad_t q;
    int j;
    for (int i = 0; i < 4; i++) begin
      lb[i] = v[i];
      rb[i] = v[4+i];
    end
    q.lf = split_corners(lb, lt0, lt1, lb0, lb1);
    q.rf = split_corners(rb, rt0, rt1, rb0, rb1);
    a[0] = nearer(lt0, lt1, v[9]);
    a[1] = nearer(lb0, lb1, v[9]);
    a[2] = nearer(rt0, rt1, v[8]);
    a[3] = nearer(rb0, rb1, v[8]);
    for (int i = 0; i < 4; i++) begin
      tmp = a[i];
      j = i;
      while (j > 0 && px(tmp) < px(s[j-1])) begin
        s[j] = s[j-1];
        j--;
      end
      s[j] = tmp;
    end
    if (py(s[0]) < py(s[1])) begin
      q.tl = s[0]; q.bl = s[1];
    end else begin
      q.tl = s[1]; q.bl = s[0];
    end
    if (py(s[2]) < py(s[3])) begin
      q.tr = s[2]; q.br = s[3];
    end else begin
      q.tr = s[3]; q.br = s[2];
    end
    return q;
  endfunction

  function automatic pt_t mk(int x, int y);
    return {CB'(x), CB'(y)};
  endfunction

  task automatic report(string what, pt_t got, pt_t want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    errors++;
  endtask

  // checker, predictor feed and watchdog
  always @(posedge clk) begin
    quad_t w;
    bit moved;
    if (rst_n) begin
      moved = 0;
      if (in_valid && !in_stall) begin
        w = cur_typed ? cur_quad : select_quad(in_v);
        quads_due = {quads_due, w};
        moved = 1;
      end
      if (out_valid && !out_stall) begin
        moved = 1;
        if (quads_due.size() == 0) begin
          report("unexpected transfer", out_top_left, '0);
        end else begin
          w = quads_due.pop_front();
          if (out_top_left !== w.tl) report("top_left", out_top_left, w.tl);
          if (out_top_right !== w.tr) report("top_right", out_top_right, w.tr);
          if (out_bottom_right !== w.br) report("bottom_right", out_bottom_right, w.br);
          if (out_bottom_left !== w.bl) report("bottom_left", out_bottom_left, w.bl);
          if (out_left_fallback !== w.lf)
            report("left_fallback", pt_t'(out_left_fallback), pt_t'(w.lf));
          if (out_right_fallback !== w.rf)
            report("right_fallback", pt_t'(out_right_fallback), pt_t'(w.rf));
        end
      end
      quiet <= moved ? 0 : quiet + 1;
      if (quiet >= WATCH_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (hold_cnt != 0) begin
      out_stall <= 1;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_req != hold_seen) begin
      out_stall <= 1;
      hold_seen <= hold_req;
      hold_cnt <= HOLD_CYCLES;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle);
    end
  end

  task automatic send(pt_t v [10], bit typed, quad_t q);
    if ($urandom_range(99) < tx_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    cur_typed <= typed;
    cur_quad <= q;
    in_valid <= 1;
    for (int i = 0; i < 10; i++) in_v[i] <= v[i];
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic void add_row(pt_t v [10], bit typed, quad_t q);
    row_t r;
    r.v = v;
    r.typed = typed;
    r.q = q;
    rows = {rows, r};
  endfunction

  // corners of an upright bar around (cx, cy), in shuffled order
  function automatic void bar_at(int cx, int cy, int hw, int hh, output pt_t c [4]);
    pt_t t;
    int k;
    c[0] = mk(cx - hw + $urandom_range(2), cy - hh + $urandom_range(2));
    c[1] = mk(cx + hw + $urandom_range(2), cy - hh + $urandom_range(2));
    c[2] = mk(cx - hw + $urandom_range(2), cy + hh + $urandom_range(2));
    c[3] = mk(cx + hw + $urandom_range(2), cy + hh + $urandom_range(2));
    for (int i = 3; i > 0; i--) begin
      k = $urandom_range(i);
      t = c[i]; c[i] = c[k]; c[k] = t;
    end
  endfunction

  function automatic void random_item(output pt_t v [10]);
    int mode, lx, rx, cy, hw, hh;
    pt_t c [4];
    mode = $urandom_range(99);
    if (mode < 70) begin
      lx = $urandom_range(4000) - 2000;
      rx = lx + $urandom_range(3000);
      cy = $urandom_range(4000) - 2000;
      hw = $urandom_range(1, 15);
      hh = $urandom_range(20, 400);
      if ($urandom_range(1)) begin
        lx = rx;
        rx = lx - $urandom_range(3000);
      end
      bar_at(lx, cy, hw, hh, c);
      for (int i = 0; i < 4; i++) v[i] = c[i];
      bar_at(rx, cy + $urandom_range(60) - 30, hw, hh, c);
      for (int i = 0; i < 4; i++) v[4+i] = c[i];
      v[8] = mk(lx + $urandom_range(2), cy);
      v[9] = mk(rx + $urandom_range(2), cy);
    end else if (mode < 85) begin
      for (int i = 0; i < 10; i++) v[i] = mk($urandom_range(3) - 1, $urandom_range(3) - 1);
    end else begin
      for (int i = 0; i < 10; i++) v[i] = $urandom;
    end
  endfunction

  initial begin
    pt_t v [10];
    quad_t q;

    for (int i = 0; i < 10; i++) v[i] = '0;
    q = '{tl: '0, tr: '0, br: '0, bl: '0, lf: 1, rf: 1};
    add_row(v, 1, q);
    for (int i = 0; i < 10; i++) v[i] = '1;
    q = '{tl: '1, tr: '1, br: '1, bl: '1, lf: 1, rf: 1};
    add_row(v, 1, q);
    // upright bars, then swapped sides
    v = '{mk(0, 0), mk(2, 0), mk(0, 100), mk(2, 100),
          mk(200, 0), mk(202, 0), mk(200, 100), mk(202, 100), mk(1, 50), mk(201, 50)};
    add_row(v, 0, q);
    v = '{mk(200, 100), mk(202, 0), mk(200, 0), mk(202, 100),
          mk(2, 100), mk(0, 0), mk(0, 100), mk(2, 0), mk(201, 50), mk(1, 50)};
    add_row(v, 0, q);
    // square bar: equal distances, lower index wins
    v = '{mk(0, 0), mk(10, 0), mk(0, 10), mk(10, 10),
          mk(50, 0), mk(60, 0), mk(50, 10), mk(60, 10), mk(5, 5), mk(55, 5)};
    add_row(v, 0, q);
    // chained nearest corners that still form two pairs, no fallback
    v = '{mk(0, 0), mk(0, 1), mk(0, 3), mk(0, 7),
          mk(9, 7), mk(9, 3), mk(9, 1), mk(9, 0), mk(0, 3), mk(9, 3)};
    add_row(v, 0, q);
    // equal pair y sums
    v = '{mk(0, 5), mk(100, 5), mk(0, -5), mk(100, -5),
          mk(300, 5), mk(400, 5), mk(300, -5), mk(400, -5), mk(50, 0), mk(350, 0)};
    add_row(v, 0, q);
    // equal x across bars, equal y in a couple
    v = '{mk(5, 0), mk(5, 1), mk(5, 20), mk(5, 21),
          mk(5, 0), mk(5, 1), mk(5, 20), mk(5, 21), mk(5, 10), mk(5, 10)};
    add_row(v, 0, q);
    // coordinate extremes
    v = '{mk(-32768, -32768), mk(-32768, -32767), mk(32767, 32767), mk(32767, 32766),
          mk(32767, -32768), mk(32766, -32768), mk(-32768, 32767), mk(-32767, 32767),
          mk(-32768, 0), mk(32767, 0)};
    add_row(v, 0, q);
    v = '{mk(32767, 32767), mk(-32768, -32768), mk(32767, -32768), mk(-32768, 32767),
          mk(0, 0), mk(32767, 32767), mk(-1, -1), mk(1, 1),
          mk(32767, 32767), mk(-32768, -32768)};
    add_row(v, 0, q);
    v = '{32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_F0F0, 32'hF0F0_0F0F,
          32'h8000_7FFF, 32'h7FFF_8000, 32'h0001_FFFF, 32'hFFFF_0001,
          32'h1234_8765, 32'h8765_1234};
    add_row(v, 0, q);

    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    foreach (rows[i]) send(rows[i].v, rows[i].typed, rows[i].q);

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle = (ph == 0) ? 22 : (ph == 1) ? 48 : 0;
      rx_idle = (ph == 0) ? 48 : (ph == 1) ? 22 : 0;
      if (ph == 2) hold_req = 1;
      repeat (433) begin
        random_item(v);
        send(v, 0, q);
      end
    end
    in_valid <= 0;

    while (quads_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && quads_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
